FILE: src/x86mov_pkg.sv
// Shared types, opcode patterns and decode helpers for the 8086 MOV decoder.
// Used by every module under src; depends on nothing else.
`default_nettype none

package x86mov_pkg;

   // Opcode patterns of the four MOV forms, matched against the high opcode bits.
   localparam logic [5:0] OPC_RM_REG  = 6'b100010;
   localparam logic [6:0] OPC_IMM_RM  = 7'b1100011;
   localparam logic [3:0] OPC_IMM_REG = 4'b1011;
   localparam logic [5:0] OPC_ACC     = 6'b101000;

   localparam logic [2:0] RM_DIRECT    = 3'b110;
   localparam logic [1:0] MOD_MEM      = 2'b00;
   localparam logic [1:0] MOD_DISP8    = 2'b01;
   localparam logic [1:0] MOD_DISP16   = 2'b10;
   localparam logic [1:0] MOD_REGISTER = 2'b11;
   localparam logic [7:0] SEXT_HIGH    = 8'hFF;

   typedef enum logic [2:0] {
      FORM_RM_REG  = 3'd0,
      FORM_IMM_RM  = 3'd1,
      FORM_IMM_REG = 3'd2,
      FORM_ACC     = 3'd3,
      FORM_UNKNOWN = 3'd4
   } form_type;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_MODRM   = 3'd1,
      PH_DISP_LO = 3'd2,
      PH_DISP_HI = 3'd3,
      PH_IMM_LO  = 3'd4,
      PH_IMM_HI  = 3'd5
   } phase_type;

   typedef struct packed {
      form_type           form;
      logic               dir_bit;
      logic               wide;
      logic [2:0]         reg_field;
      logic [1:0]         mode_field;
      logic [2:0]         rm_field;
      logic               direct_address;
      logic signed [15:0] displacement;
      logic [15:0]        immediate;
      logic [7:0]         raw_opcode;
      logic [2:0]         length;
   } rec_type;

   // Handshake state passed between the pipeline stages.
   typedef struct packed {
      logic vld;
      logic adv;
   } stage_ctl_type;

   function automatic form_type form_of(input logic [7:0] op);
      form_type f;
      if (op[7:2] == OPC_RM_REG) f = FORM_RM_REG;
      else if (op[7:1] == OPC_IMM_RM) f = FORM_IMM_RM;
      else if (op[7:4] == OPC_IMM_REG) f = FORM_IMM_REG;
      else if (op[7:2] == OPC_ACC) f = FORM_ACC;
      else f = FORM_UNKNOWN;
      return f;
   endfunction

   // Number of displacement bytes, 0 to 2.
   function automatic logic [1:0] disp_len(input logic [7:0] op, input logic [7:0] modrm);
      form_type   f;
      logic [1:0] n;
      f = form_of(op);
      n = 2'd0;
      case (f)
         FORM_ACC: n = 2'd2;
         FORM_RM_REG, FORM_IMM_RM: begin
            case (modrm[7:6])
               MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
               MOD_DISP8:  n = 2'd1;
               MOD_DISP16: n = 2'd2;
               default:    n = 2'd0;
            endcase
         end
         default: n = 2'd0;
      endcase
      return n;
   endfunction

   // Number of immediate bytes, 0 to 2.
   function automatic logic [1:0] imm_len(input logic [7:0] op);
      form_type   f;
      logic [1:0] n;
      f = form_of(op);
      case (f)
         FORM_IMM_RM:  n = op[0] ? 2'd2 : 2'd1;
         FORM_IMM_REG: n = op[3] ? 2'd2 : 2'd1;
         default:      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: src/x86mov_in_stage.sv
// Input register for the code byte stream.
// Depends on x86mov_pkg for the stage control struct.
`default_nettype none

module x86mov_in_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_code_byte,
   input  wire logic                    adv,
   output x86mov_pkg::stage_ctl_type    ctl,
   output logic [7:0]                   code_byte
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] byte_ff;

   // The register takes a new byte whenever its current one moves on or it is empty.
   assign req_stall = vld_ff && !adv;

   always_comb begin
      vld_in = vld_ff;
      if (!req_stall) vld_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) byte_ff <= req_code_byte;
   end

   assign ctl.vld   = vld_ff;
   assign ctl.adv   = adv;
   assign code_byte = byte_ff;

endmodule

`default_nettype wire

FILE: src/x86mov_parser.sv
// Parse state machine: phase, held instruction bytes and the decoded record.
// Depends on x86mov_pkg for phase, form and record types and decode helpers.
`default_nettype none

module x86mov_parser (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire x86mov_pkg::stage_ctl_type ctl,
   input  wire logic [7:0]                code_byte,
   output logic                           done,
   output x86mov_pkg::rec_type            rec
);

   x86mov_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] imm_ff, imm_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  dlen;
   logic [1:0]  ilen;
   x86mov_pkg::form_type f;

   // Lengths come from the held opcode; in the ModRM phase the incoming byte is the
   // ModRM byte.
   assign dlen = x86mov_pkg::disp_len(opcode_ff,
                    (phase_ff == x86mov_pkg::PH_MODRM) ? code_byte : modrm_ff);
   assign ilen = x86mov_pkg::imm_len(opcode_ff);

   // Next state and holds.
   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      modrm_in  = modrm_ff;
      disp_in   = disp_ff;
      imm_in    = imm_ff;
      count_in  = count_ff + 3'd1;
      done      = 1'b0;
      case (phase_ff)
         x86mov_pkg::PH_MODRM: begin
            modrm_in = code_byte;
            if (dlen != 2'd0) phase_in = x86mov_pkg::PH_DISP_LO;
            else if (ilen != 2'd0) phase_in = x86mov_pkg::PH_IMM_LO;
            else done = 1'b1;
         end
         x86mov_pkg::PH_DISP_LO: begin
            if (dlen == 2'd2) begin
               disp_in  = {8'd0, code_byte};
               phase_in = x86mov_pkg::PH_DISP_HI;
            end else begin
               disp_in = {(code_byte[7] ? x86mov_pkg::SEXT_HIGH : 8'd0), code_byte};
               if (ilen != 2'd0) phase_in = x86mov_pkg::PH_IMM_LO;
               else done = 1'b1;
            end
         end
         x86mov_pkg::PH_DISP_HI: begin
            disp_in = {code_byte, disp_ff[7:0]};
            if (ilen != 2'd0) phase_in = x86mov_pkg::PH_IMM_LO;
            else done = 1'b1;
         end
         x86mov_pkg::PH_IMM_LO: begin
            imm_in = {8'd0, code_byte};
            if (ilen == 2'd2) phase_in = x86mov_pkg::PH_IMM_HI;
            else done = 1'b1;
         end
         x86mov_pkg::PH_IMM_HI: begin
            imm_in = {code_byte, imm_ff[7:0]};
            done   = 1'b1;
         end
         default: begin
            // Opcode byte; unused phase codes land here as well.
            opcode_in = code_byte;
            modrm_in  = 8'd0;
            disp_in   = 16'd0;
            imm_in    = 16'd0;
            count_in  = 3'd1;
            case (x86mov_pkg::form_of(code_byte))
               x86mov_pkg::FORM_RM_REG,
               x86mov_pkg::FORM_IMM_RM:  phase_in = x86mov_pkg::PH_MODRM;
               x86mov_pkg::FORM_IMM_REG: phase_in = x86mov_pkg::PH_IMM_LO;
               x86mov_pkg::FORM_ACC:     phase_in = x86mov_pkg::PH_DISP_LO;
               default:                  done = 1'b1;
            endcase
         end
      endcase
      if (done) phase_in = x86mov_pkg::PH_OPCODE;
   end

   // Record built from the holds as updated by this byte.
   assign f = x86mov_pkg::form_of(opcode_in);

   always_comb begin
      rec            = '0;
      rec.form       = f;
      rec.raw_opcode = opcode_in;
      rec.length     = count_in;
      case (f)
         x86mov_pkg::FORM_RM_REG, x86mov_pkg::FORM_IMM_RM: begin
            rec.dir_bit        = (f == x86mov_pkg::FORM_RM_REG) ? opcode_in[1] : 1'b0;
            rec.wide           = opcode_in[0];
            rec.reg_field      = modrm_in[5:3];
            rec.mode_field     = modrm_in[7:6];
            rec.rm_field       = modrm_in[2:0];
            rec.direct_address = (modrm_in[7:6] == x86mov_pkg::MOD_MEM) &&
                                 (modrm_in[2:0] == x86mov_pkg::RM_DIRECT);
            rec.displacement   = disp_in;
            rec.immediate      = imm_in;
         end
         x86mov_pkg::FORM_IMM_REG: begin
            rec.wide       = opcode_in[3];
            rec.reg_field  = opcode_in[2:0];
            rec.mode_field = x86mov_pkg::MOD_REGISTER;
            rec.immediate  = imm_in;
         end
         x86mov_pkg::FORM_ACC: begin
            rec.dir_bit        = opcode_in[1];
            rec.wide           = opcode_in[0];
            rec.rm_field       = x86mov_pkg::RM_DIRECT;
            rec.direct_address = 1'b1;
            rec.displacement   = disp_in;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= x86mov_pkg::PH_OPCODE;
         opcode_ff <= 8'd0;
         modrm_ff  <= 8'd0;
         disp_ff   <= 16'd0;
         imm_ff    <= 16'd0;
         count_ff  <= 3'd0;
      end else if (ctl.adv) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         modrm_ff  <= modrm_in;
         disp_ff   <= disp_in;
         imm_ff    <= imm_in;
         count_ff  <= count_in;
      end
   end

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      (ctl.adv && done) |=> (phase_ff == x86mov_pkg::PH_OPCODE))
      else $error("parser did not return to the opcode phase after a record");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      done |-> (rec.length >= 3'd1 && rec.length <= 3'd6))
      else $error("record length out of range");

   a_unknown_len: assert property (@(posedge clock) disable iff (reset)
      (done && rec.form == x86mov_pkg::FORM_UNKNOWN) |-> (rec.length == 3'd1))
      else $error("unknown opcode record longer than one byte");

   a_adv_needs_byte: assert property (@(posedge clock) disable iff (reset)
      ctl.adv |-> ctl.vld)
      else $error("parser advanced without a byte");

endmodule

`default_nettype wire

FILE: src/x86mov_rsp_stage.sv
// Result register that holds one decoded record until it is taken.
// Depends on x86mov_pkg for the record type.
`default_nettype none

module x86mov_rsp_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire x86mov_pkg::rec_type rec,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     blocked,
   output x86mov_pkg::rec_type      rsp_rec
);

   logic                vld_ff;
   logic                vld_in;
   x86mov_pkg::rec_type rec_ff;

   assign blocked = vld_ff && rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      if (load) vld_in = 1'b1;
      else if (!rsp_stall) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) rec_ff <= rec;
   end

   assign rsp_valid = vld_ff;
   assign rsp_rec   = rec_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !blocked)
      else $error("waiting record overwritten");

endmodule

`default_nettype wire

FILE: src/x86_16_mov_decoder.sv
// Top level of the 8086 MOV decoder: input register, parser and result register.
// Depends on x86mov_pkg, x86mov_in_stage, x86mov_parser and x86mov_rsp_stage.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_code_byte
//   rsp      out        rsp_valid/rsp_stall  rsp_form .. rsp_length
//
// One code byte is taken per cycle while req_stall is low; the phase register
// updates once per byte. The last byte of an instruction is held in the input
// register; the record then loads the result register and raises rsp_valid.
// Reset is synchronous and returns the parser to the opcode phase.
// While a record waits under rsp_stall, at most one further byte is taken.
`default_nettype none

module x86_16_mov_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_code_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_form,
   output logic                    rsp_dir_bit,
   output logic                    rsp_wide,
   output logic [2:0]              rsp_reg_field,
   output logic [1:0]              rsp_mode_field,
   output logic [2:0]              rsp_rm_field,
   output logic                    rsp_direct_address,
   output logic signed [15:0]      rsp_displacement,
   output logic [15:0]             rsp_immediate,
   output logic [7:0]              rsp_raw_opcode,
   output logic [2:0]              rsp_length
);

   x86mov_pkg::stage_ctl_type ctl;
   x86mov_pkg::rec_type       rec;
   x86mov_pkg::rec_type       rsp_rec;
   logic [7:0]                code_byte;
   logic                      done;
   logic                      blocked;
   logic                      adv;

   // A byte moves on unless a waiting record has not been taken yet.
   assign adv = ctl.vld && !blocked;

   x86mov_in_stage u_in (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_code_byte (req_code_byte),
      .adv           (adv),
      .ctl           (ctl),
      .code_byte     (code_byte)
   );

   x86mov_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .code_byte (code_byte),
      .done      (done),
      .rec       (rec)
   );

   x86mov_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (adv && done),
      .rec       (rec),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .blocked   (blocked),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_form           = rsp_rec.form;
   assign rsp_dir_bit        = rsp_rec.dir_bit;
   assign rsp_wide           = rsp_rec.wide;
   assign rsp_reg_field      = rsp_rec.reg_field;
   assign rsp_mode_field     = rsp_rec.mode_field;
   assign rsp_rm_field       = rsp_rec.rm_field;
   assign rsp_direct_address = rsp_rec.direct_address;
   assign rsp_displacement   = rsp_rec.displacement;
   assign rsp_immediate      = rsp_rec.immediate;
   assign rsp_raw_opcode     = rsp_rec.raw_opcode;
   assign rsp_length         = rsp_rec.length;

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for x86_16_mov_decoder: feeds directed and random 8086 byte
// streams and checks every decoded record against an in-bench model of the parser.
// Depends on x86mov_pkg for the record layout, form codes and opcode patterns.
`default_nettype none

module testbench;

   localparam int ITEMS_PER_PHASE = 356;
   localparam int HOLD_CYCLES = 300;
   localparam int DIRECTED_LEN = 25;

   // Directed stream: unknown opcodes at both byte extremes, register/memory forms
   // with no displacement, a negative 8-bit displacement and a direct address,
   // immediate to memory with a nonzero reg field and the longest encoding,
   // immediate to register in both widths, and the accumulator form.
   localparam logic [DIRECTED_LEN*8-1:0] DIRECTED_STREAM = {
      8'h00, 8'hFF,
      8'h88, 8'h07,
      8'h8A, 8'h46, 8'h80,
      8'h8B, 8'h36, 8'h34, 8'h12,
      8'hC7, 8'hBE, 8'h00, 8'h80, 8'hFF, 8'hFF,
      8'hB0, 8'h7F,
      8'hBF, 8'hFF, 8'hFF,
      8'hA3, 8'hFF, 8'h7F
   };

   class mov_scoreboard;
      x86mov_pkg::rec_type   pending_q[$];
      int                    errors;
      x86mov_pkg::phase_type stage;
      logic [7:0]            opcode_r;
      logic [7:0]            modrm_r;
      logic [15:0]           disp_r;
      logic [15:0]           imm_r;
      logic [2:0]            count_r;

      function new();
         errors = 0;
         stage = x86mov_pkg::PH_OPCODE;
         opcode_r = '0;
         modrm_r = '0;
         disp_r = '0;
         imm_r = '0;
         count_r = '0;
      endfunction

      task report(input string msg);
         errors++;
         $display("%0t: mismatch: %s", $time, msg);
      endtask

      function x86mov_pkg::form_type classify(input logic [7:0] op);
         if (op[7:2] == x86mov_pkg::OPC_RM_REG) return x86mov_pkg::FORM_RM_REG;
         if (op[7:1] == x86mov_pkg::OPC_IMM_RM) return x86mov_pkg::FORM_IMM_RM;
         if (op[7:4] == x86mov_pkg::OPC_IMM_REG) return x86mov_pkg::FORM_IMM_REG;
         if (op[7:2] == x86mov_pkg::OPC_ACC) return x86mov_pkg::FORM_ACC;
         return x86mov_pkg::FORM_UNKNOWN;
      endfunction

      function int disp_bytes();
         x86mov_pkg::form_type f;
         f = classify(opcode_r);
         if (f == x86mov_pkg::FORM_ACC) return 2;
         if (f != x86mov_pkg::FORM_RM_REG && f != x86mov_pkg::FORM_IMM_RM) return 0;
         case (modrm_r[7:6])
            x86mov_pkg::MOD_MEM:
               return (modrm_r[2:0] == x86mov_pkg::RM_DIRECT) ? 2 : 0;
            x86mov_pkg::MOD_DISP8:  return 1;
            x86mov_pkg::MOD_DISP16: return 2;
            default:                return 0;
         endcase
      endfunction

      function int imm_bytes();
         case (classify(opcode_r))
            x86mov_pkg::FORM_IMM_RM:  return opcode_r[0] ? 2 : 1;
            x86mov_pkg::FORM_IMM_REG: return opcode_r[3] ? 2 : 1;
            default:                  return 0;
         endcase
      endfunction

      // Builds the record of the finished instruction; unused fields stay zero.
      function void emit_record();
         x86mov_pkg::rec_type  r;
         x86mov_pkg::form_type f;
         f = classify(opcode_r);
         r = '0;
         r.form = f;
         r.raw_opcode = opcode_r;
         r.length = count_r;
         case (f)
            x86mov_pkg::FORM_RM_REG, x86mov_pkg::FORM_IMM_RM: begin
               r.dir_bit = (f == x86mov_pkg::FORM_RM_REG) ? opcode_r[1] : 1'b0;
               r.wide = opcode_r[0];
               r.reg_field = modrm_r[5:3];
               r.mode_field = modrm_r[7:6];
               r.rm_field = modrm_r[2:0];
               r.direct_address = (modrm_r[7:6] == x86mov_pkg::MOD_MEM) &&
                                  (modrm_r[2:0] == x86mov_pkg::RM_DIRECT);
               r.displacement = disp_r;
               r.immediate = imm_r;
            end
            x86mov_pkg::FORM_IMM_REG: begin
               r.wide = opcode_r[3];
               r.reg_field = opcode_r[2:0];
               r.mode_field = x86mov_pkg::MOD_REGISTER;
               r.immediate = imm_r;
            end
            x86mov_pkg::FORM_ACC: begin
               r.dir_bit = opcode_r[1];
               r.wide = opcode_r[0];
               r.rm_field = x86mov_pkg::RM_DIRECT;
               r.direct_address = 1'b1;
               r.displacement = disp_r;
            end
            default: ;
         endcase
         pending_q.push_back(r);
         stage = x86mov_pkg::PH_OPCODE;
      endfunction

      function void finish_disp();
         if (imm_bytes() > 0) stage = x86mov_pkg::PH_IMM_LO;
         else emit_record();
      endfunction

      // Advances the parse by one accepted code byte.
      function void note_byte(input logic [7:0] b);
         if (stage != x86mov_pkg::PH_OPCODE) count_r = count_r + 3'd1;
         case (stage)
            x86mov_pkg::PH_MODRM: begin
               modrm_r = b;
               if (disp_bytes() > 0) stage = x86mov_pkg::PH_DISP_LO;
               else finish_disp();
            end
            x86mov_pkg::PH_DISP_LO: begin
               if (disp_bytes() == 2) begin
                  disp_r = {8'h00, b};
                  stage = x86mov_pkg::PH_DISP_HI;
               end else begin
                  disp_r = {{8{b[7]}}, b};
                  finish_disp();
               end
            end
            x86mov_pkg::PH_DISP_HI: begin
               disp_r[15:8] = b;
               finish_disp();
            end
            x86mov_pkg::PH_IMM_LO: begin
               imm_r = {8'h00, b};
               if (imm_bytes() == 2) stage = x86mov_pkg::PH_IMM_HI;
               else emit_record();
            end
            x86mov_pkg::PH_IMM_HI: begin
               imm_r[15:8] = b;
               emit_record();
            end
            default: begin
               opcode_r = b;
               modrm_r = '0;
               disp_r = '0;
               imm_r = '0;
               count_r = 3'd1;
               case (classify(b))
                  x86mov_pkg::FORM_RM_REG,
                  x86mov_pkg::FORM_IMM_RM:  stage = x86mov_pkg::PH_MODRM;
                  x86mov_pkg::FORM_IMM_REG: stage = x86mov_pkg::PH_IMM_LO;
                  x86mov_pkg::FORM_ACC:     stage = x86mov_pkg::PH_DISP_LO;
                  default:                  emit_record();
               endcase
            end
         endcase
      endfunction

      task compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
         if (got !== want)
            report($sformatf("%s got %h, expected %h", name, got, want));
      endtask

      task check_record(input x86mov_pkg::rec_type got);
         x86mov_pkg::rec_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("record with opcode %h and no transaction waiting",
                             got.raw_opcode));
         end else begin
            want = pending_q.pop_front();
            compare_field("form", 16'(got.form), 16'(want.form));
            compare_field("dir_bit", 16'(got.dir_bit), 16'(want.dir_bit));
            compare_field("wide", 16'(got.wide), 16'(want.wide));
            compare_field("reg_field", 16'(got.reg_field), 16'(want.reg_field));
            compare_field("mode_field", 16'(got.mode_field), 16'(want.mode_field));
            compare_field("rm_field", 16'(got.rm_field), 16'(want.rm_field));
            compare_field("direct_address", 16'(got.direct_address),
                          16'(want.direct_address));
            compare_field("displacement", got.displacement, want.displacement);
            compare_field("immediate", got.immediate, want.immediate);
            compare_field("raw_opcode", 16'(got.raw_opcode), 16'(want.raw_opcode));
            compare_field("length", 16'(got.length), 16'(want.length));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_code_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_form;
   logic               rsp_dir_bit;
   logic               rsp_wide;
   logic [2:0]         rsp_reg_field;
   logic [1:0]         rsp_mode_field;
   logic [2:0]         rsp_rm_field;
   logic               rsp_direct_address;
   logic signed [15:0] rsp_displacement;
   logic [15:0]        rsp_immediate;
   logic [7:0]         rsp_raw_opcode;
   logic [2:0]         rsp_length;

   mov_scoreboard board;
   int            idle_pct;
   int            stall_pct;
   logic          hold_off;

   x86_16_mov_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_code_byte      (req_code_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_form           (rsp_form),
      .rsp_dir_bit        (rsp_dir_bit),
      .rsp_wide           (rsp_wide),
      .rsp_reg_field      (rsp_reg_field),
      .rsp_mode_field     (rsp_mode_field),
      .rsp_rm_field       (rsp_rm_field),
      .rsp_direct_address (rsp_direct_address),
      .rsp_displacement   (rsp_displacement),
      .rsp_immediate      (rsp_immediate),
      .rsp_raw_opcode     (rsp_raw_opcode),
      .rsp_length         (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("x86_16_mov_decoder regression: fail");
      $finish;
   end

   // The hold-off flag changes at rising edges only, so it is stable when read here.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : sample_rsp
      x86mov_pkg::rec_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.form = x86mov_pkg::form_type'(rsp_form);
         got.dir_bit = rsp_dir_bit;
         got.wide = rsp_wide;
         got.reg_field = rsp_reg_field;
         got.mode_field = rsp_mode_field;
         got.rm_field = rsp_rm_field;
         got.direct_address = rsp_direct_address;
         got.displacement = rsp_displacement;
         got.immediate = rsp_immediate;
         got.raw_opcode = rsp_raw_opcode;
         got.length = rsp_length;
         board.check_record(got);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
      @(negedge clock);
   endtask

   // Mostly complete MOV instructions with random content; the rest are lone
   // random bytes or instructions cut short.
   task automatic send_random_instruction(output int sent);
      logic [7:0] code[$];
      logic [7:0] op;
      logic [7:0] modrm;
      int         pick;
      int         n_disp;
      int         n_imm;
      int         keep;
      pick = $urandom_range(0, 19);
      op = 8'($urandom);
      modrm = 8'($urandom);
      if ($urandom_range(0, 3) == 0) modrm[2:0] = x86mov_pkg::RM_DIRECT;
      n_disp = 0;
      n_imm = 0;
      if (pick < 3) begin
         code.push_back(op);
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               op = {x86mov_pkg::OPC_RM_REG, op[1:0]};
               code.push_back(op);
               code.push_back(modrm);
            end
            1: begin
               op = {x86mov_pkg::OPC_IMM_RM, op[0]};
               code.push_back(op);
               code.push_back(modrm);
               n_imm = op[0] ? 2 : 1;
            end
            2: begin
               op = {x86mov_pkg::OPC_IMM_REG, op[3:0]};
               code.push_back(op);
               n_imm = op[3] ? 2 : 1;
            end
            default: begin
               op = {x86mov_pkg::OPC_ACC, op[1:0]};
               code.push_back(op);
               n_disp = 2;
            end
         endcase
         if (code.size() == 2) begin
            case (modrm[7:6])
               x86mov_pkg::MOD_MEM:
                  n_disp = (modrm[2:0] == x86mov_pkg::RM_DIRECT) ? 2 : 0;
               x86mov_pkg::MOD_DISP8:  n_disp = 1;
               x86mov_pkg::MOD_DISP16: n_disp = 2;
               default:                n_disp = 0;
            endcase
         end
         repeat (n_disp + n_imm) code.push_back(8'($urandom));
         if (pick < 5 && code.size() > 1) begin
            keep = $urandom_range(1, code.size() - 1);
            while (code.size() > keep) void'(code.pop_back());
         end
      end
      foreach (code[i]) send_byte(code[i]);
      sent = code.size();
   endtask

   initial begin : stimulus
      int phase_idx;
      int sent;
      int total;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_code_byte = '0;
      idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++)
         send_byte(DIRECTED_STREAM[(DIRECTED_LEN - 1 - i) * 8 +: 8]);

      for (phase_idx = 0; phase_idx < 4; phase_idx++) begin
         case (phase_idx)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 81;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 81;
            end
            default: begin
               idle_pct = 27;
               stall_pct = 27;
            end
         endcase
         // With the sender running flat out, a long receiver hold-off backs the
         // pipeline up until the block stalls its input.
         if (phase_idx == 0) begin
            fork
               begin
                  @(posedge clock);
                  hold_off = 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         total = 0;
         while (total < ITEMS_PER_PHASE) begin
            send_random_instruction(sent);
            total += sent;
         end
      end

      req_valid <= 1'b0;
      stall_pct = 0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0) begin
         $display("x86_16_mov_decoder regression: pass");
      end else begin
         $display("x86_16_mov_decoder regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/x86mov_pkg.sv
src/x86mov_in_stage.sv
src/x86mov_parser.sv
src/x86mov_rsp_stage.sv
src/x86_16_mov_decoder.sv
test/testbench.sv
